// ----- rtl/pfcs_pkg.sv -----
// Shared types and constants for the packet freshness and clock sync block.
package pfcs_pkg;

   localparam int STAMP_BITS     = 48;
   localparam int NOW_BITS       = 48;
   localparam int SEQ_BITS       = 16;
   localparam int PLAYER_BITS    = 3;
   localparam int CFG_BITS       = 32;
   localparam int COUNT_BITS     = 16;
   localparam int CSR_DATA_BITS  = 48;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CFG_BITS-1:0]    GRACE_RESET  = 32'd1000000;
   localparam logic [CFG_BITS-1:0]    MARGIN_RESET = 32'd1000000;
   localparam logic [STAMP_BITS-1:0]  MARKER_RESET = '0;
   localparam logic [COUNT_BITS-1:0]  ACCEPT_MAX   = '1;
   localparam logic [COUNT_BITS-1:0]  RESYNC_MIN   = 16'd2;
   localparam logic [PLAYER_BITS-1:0] PLAYER_ONE   = 3'd1;
   localparam logic                   CMD_RESTART  = 1'b1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_GRACE  = 2'd0,
      CSR_MARGIN = 2'd1,
      CSR_MARKER = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      STATUS_OK      = 3'd0,
      STATUS_MARKER  = 3'd1,
      STATUS_TOO_OLD = 3'd2,
      STATUS_ORDER   = 3'd3,
      STATUS_RESET   = 3'd4
   } status_type;

   typedef struct packed {
      logic                          command;
      logic [NOW_BITS-1:0]           now_us;
      logic [PLAYER_BITS-1:0]        pkt_player;
      logic [SEQ_BITS-1:0]           pkt_number;
      logic signed [STAMP_BITS-1:0]  pkt_timestamp;
   } req_type;

   typedef struct packed {
      logic                          accepted;
      status_type                    status;
      logic [SEQ_BITS-1:0]           dropped_count;
      logic                          clock_adjusted;
      logic signed [STAMP_BITS-1:0]  local_time;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TIME,
      ST_CHECK,
      ST_SCAN,
      ST_DIVIDE,
      ST_ADJUST,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic take_item;
      logic do_time;
      logic do_check;
      logic scan_step;
      logic div_step;
      logic do_adjust;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic restart;
      logic start_resync;
      logic scan_last;
      logic num_zero;
      logic div_last;
   } stat_type;

endpackage

// ----- rtl/pfcs_ctrl.sv -----
// Sequencer for the packet freshness and clock sync block.
module pfcs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  pfcs_pkg::stat_type stat,
   output pfcs_pkg::cmd_type  cmd
);

   pfcs_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfcs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pfcs_pkg::ST_IDLE: begin
            if (req_valid) state_in = pfcs_pkg::ST_TIME;
         end
         pfcs_pkg::ST_TIME: begin
            state_in = stat.restart ? pfcs_pkg::ST_DONE : pfcs_pkg::ST_CHECK;
         end
         pfcs_pkg::ST_CHECK: begin
            state_in = stat.start_resync ? pfcs_pkg::ST_SCAN : pfcs_pkg::ST_DONE;
         end
         pfcs_pkg::ST_SCAN: begin
            if (stat.scan_last) state_in = pfcs_pkg::ST_DIVIDE;
         end
         pfcs_pkg::ST_DIVIDE: begin
            if (stat.num_zero) state_in = pfcs_pkg::ST_DONE;
            else if (stat.div_last) state_in = pfcs_pkg::ST_ADJUST;
         end
         pfcs_pkg::ST_ADJUST: begin
            state_in = pfcs_pkg::ST_DONE;
         end
         pfcs_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = pfcs_pkg::ST_IDLE;
         end
         default: begin
            state_in = pfcs_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         pfcs_pkg::ST_IDLE:   cmd.take_item = req_valid;
         pfcs_pkg::ST_TIME:   cmd.do_time   = 1'b1;
         pfcs_pkg::ST_CHECK:  cmd.do_check  = 1'b1;
         pfcs_pkg::ST_SCAN:   cmd.scan_step = 1'b1;
         pfcs_pkg::ST_DIVIDE: cmd.div_step  = !stat.num_zero;
         pfcs_pkg::ST_ADJUST: cmd.do_adjust = 1'b1;
         pfcs_pkg::ST_DONE:   cmd.out_load  = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);
   assign req_stall    = (state_ff != pfcs_pkg::ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second beat taken while an item is in work");

   a_free_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> !req_stall)
      else $error("input side not freed after result load");

endmodule

// ----- rtl/pfcs_datapath.sv -----
// Datapath: configuration, epoch, peer table, checks, resync divider, result register.
module pfcs_datapath #(
   parameter int PLAYERS   = 4,
   parameter int TIME_BITS = 48
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [pfcs_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [pfcs_pkg::CSR_DATA_BITS-1:0]    csr_write_data,
   input  pfcs_pkg::req_type                     req_data,
   input  pfcs_pkg::cmd_type                     cmd,
   output pfcs_pkg::stat_type                    stat,
   output pfcs_pkg::rsp_type                     rsp_data
);

   localparam int SB = pfcs_pkg::STAMP_BITS;
   localparam int QB = pfcs_pkg::SEQ_BITS;
   localparam int CB = pfcs_pkg::CFG_BITS;
   localparam int NB = pfcs_pkg::COUNT_BITS;
   localparam int IW = $clog2(PLAYERS);
   localparam int XW = ((TIME_BITS > SB) ? TIME_BITS : SB) + 1;
   localparam int NW = $clog2(PLAYERS + 1);
   localparam int SW = XW + $clog2(PLAYERS);
   localparam int DW = $clog2(SW);

   logic [CB-1:0]              grace_ff, grace_in;
   logic [CB-1:0]              margin_ff, margin_in;
   logic [SB-1:0]              marker_ff, marker_in;
   pfcs_pkg::req_type          item_ff, item_in;
   logic [TIME_BITS-1:0]       epoch_ff, epoch_in;
   logic signed [SB-1:0]       last_stamp_ff [PLAYERS];
   logic signed [SB-1:0]       last_stamp_in [PLAYERS];
   logic [QB-1:0]              last_seq_ff [PLAYERS];
   logic [QB-1:0]              last_seq_in [PLAYERS];
   logic [NB-1:0]              count_ff, count_in;
   logic                       pending_ff, pending_in;
   logic signed [TIME_BITS-1:0] ts_ff, ts_in;
   logic [SW-1:0]              sum_ff, sum_in;
   logic [NW-1:0]              num_ff, num_in;
   logic [NW-1:0]              rem_ff, rem_in;
   logic [IW-1:0]              scan_idx_ff, scan_idx_in;
   logic [DW-1:0]              div_cnt_ff, div_cnt_in;
   logic                       acc_ff, acc_in;
   pfcs_pkg::status_type       status_ff, status_in;
   logic [QB-1:0]              dropped_ff, dropped_in;
   logic                       adj_ff, adj_in;
   pfcs_pkg::rsp_type          out_ff, out_in;

   logic [TIME_BITS-1:0]       now_t;
   logic signed [TIME_BITS-1:0] lt_calc;
   logic                       restart;
   logic                       player_ok;
   logic [IW-1:0]              player_idx;
   logic [IW-1:0]              rd_idx;
   logic signed [SB-1:0]       rd_stamp;
   logic [QB-1:0]              rd_seq;
   logic signed [XW-1:0]       ts_x, stamp_x, rd_x, grace_x, margin_x;
   logic signed [XW-1:0]       lag_x, lead_x, ahead_x;
   logic                       too_old, fresh_reset, qualify;
   logic [QB:0]                seq_next;
   logic [QB-1:0]              dropped_calc;
   pfcs_pkg::status_type       status_calc;
   logic                       accept_calc;
   logic [NB-1:0]              count_sat;
   logic [NW:0]                div_sh;
   logic                       div_ge;
   logic signed [SW:0]         floor_x;
   logic [SW-1:0]              shift;

   assign now_t      = TIME_BITS'(item_ff.now_us);
   assign lt_calc    = signed'(now_t - epoch_ff);
   assign restart    = (item_ff.command == pfcs_pkg::CMD_RESTART);
   assign player_ok  = (item_ff.pkt_player != '0) && (int'(item_ff.pkt_player) <= PLAYERS);
   assign player_idx = IW'(item_ff.pkt_player - pfcs_pkg::PLAYER_ONE);
   assign rd_idx     = cmd.scan_step ? scan_idx_ff : player_idx;
   assign rd_stamp   = last_stamp_ff[rd_idx];
   assign rd_seq     = last_seq_ff[rd_idx];

   assign ts_x     = XW'(ts_ff);
   assign stamp_x  = XW'(item_ff.pkt_timestamp);
   assign rd_x     = XW'(rd_stamp);
   assign grace_x  = signed'(XW'(grace_ff));
   assign margin_x = signed'(XW'(margin_ff));
   assign lag_x    = ts_x - stamp_x;
   assign lead_x   = stamp_x - ts_x;
   assign ahead_x  = rd_x - ts_x;

   assign too_old     = lag_x > grace_x;
   assign fresh_reset = !pending_ff && (ts_x < grace_x) && (lead_x > grace_x);
   assign qualify     = ahead_x > margin_x;

   assign seq_next     = {1'b0, rd_seq} + 1'b1;
   assign dropped_calc = (player_ok && ({1'b0, item_ff.pkt_number} > seq_next)) ?
                         (item_ff.pkt_number - rd_seq - 1'b1) : '0;

   always_comb begin
      accept_calc = 1'b0;
      if (unsigned'(item_ff.pkt_timestamp) == marker_ff) begin
         status_calc = pfcs_pkg::STATUS_MARKER;
      end else if (too_old) begin
         status_calc = pfcs_pkg::STATUS_TOO_OLD;
      end else if (!player_ok || (item_ff.pkt_number < rd_seq)) begin
         status_calc = pfcs_pkg::STATUS_ORDER;
      end else if (fresh_reset) begin
         status_calc = pfcs_pkg::STATUS_RESET;
      end else begin
         status_calc = pfcs_pkg::STATUS_OK;
         accept_calc = 1'b1;
      end
   end

   assign count_sat = (count_ff == pfcs_pkg::ACCEPT_MAX) ? count_ff : count_ff + 1'b1;

   assign div_sh  = {rem_ff, sum_ff[SW-1]};
   assign div_ge  = div_sh >= {1'b0, num_ff};
   assign floor_x = (SW+1)'(ts_x) + signed'({1'b0, sum_ff});
   assign shift   = sum_ff + SW'(floor_x[SW] && (rem_ff != '0));

   assign stat.restart      = restart;
   assign stat.start_resync = accept_calc && pending_ff && (count_sat >= pfcs_pkg::RESYNC_MIN);
   assign stat.scan_last    = (scan_idx_ff == IW'(PLAYERS - 1));
   assign stat.num_zero     = (num_ff == '0);
   assign stat.div_last     = (div_cnt_ff == DW'(SW - 1));

   always_comb begin
      grace_in  = grace_ff;
      margin_in = margin_ff;
      marker_in = marker_ff;
      if (csr_write_enable) begin
         unique case (pfcs_pkg::csr_index_type'(csr_index))
            pfcs_pkg::CSR_GRACE:  grace_in  = CB'(csr_write_data);
            pfcs_pkg::CSR_MARGIN: margin_in = CB'(csr_write_data);
            pfcs_pkg::CSR_MARKER: marker_in = SB'(csr_write_data);
            default: ;
         endcase
      end
   end

   always_comb begin
      item_in       = cmd.take_item ? req_data : item_ff;
      epoch_in      = epoch_ff;
      last_stamp_in = last_stamp_ff;
      last_seq_in   = last_seq_ff;
      count_in      = count_ff;
      pending_in    = pending_ff;
      ts_in         = ts_ff;
      sum_in        = sum_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      scan_idx_in   = scan_idx_ff;
      div_cnt_in    = div_cnt_ff;
      acc_in        = acc_ff;
      status_in     = status_ff;
      dropped_in    = dropped_ff;
      adj_in        = adj_ff;
      out_in        = out_ff;

      if (cmd.take_item) begin
         acc_in     = 1'b0;
         status_in  = pfcs_pkg::STATUS_OK;
         dropped_in = '0;
         adj_in     = 1'b0;
      end

      if (cmd.do_time) begin
         ts_in = lt_calc;
         if (restart) begin
            epoch_in = now_t;
            count_in = '0;
            for (int k = 0; k < PLAYERS; k++) begin
               last_stamp_in[k] = '0;
               last_seq_in[k]   = '0;
            end
         end
      end

      if (cmd.do_check) begin
         acc_in      = accept_calc;
         status_in   = status_calc;
         dropped_in  = dropped_calc;
         sum_in      = '0;
         num_in      = '0;
         rem_in      = '0;
         scan_idx_in = '0;
         div_cnt_in  = '0;
         if (status_calc == pfcs_pkg::STATUS_RESET) pending_in = 1'b1;
         if (accept_calc) begin
            last_stamp_in[player_idx] = item_ff.pkt_timestamp;
            last_seq_in[player_idx]   = item_ff.pkt_number;
            count_in                  = count_sat;
         end
      end

      if (cmd.scan_step) begin
         scan_idx_in = scan_idx_ff + 1'b1;
         if (qualify) begin
            sum_in = sum_ff + SW'(ahead_x);
            num_in = num_ff + 1'b1;
         end
      end

      if (cmd.div_step) begin
         div_cnt_in = div_cnt_ff + 1'b1;
         sum_in     = {sum_ff[SW-2:0], div_ge};
         rem_in     = div_ge ? NW'(div_sh - {1'b0, num_ff}) : NW'(div_sh);
      end

      if (cmd.do_adjust) begin
         epoch_in   = epoch_ff - TIME_BITS'(shift);
         pending_in = 1'b0;
         adj_in     = 1'b1;
      end

      if (cmd.out_load) begin
         out_in.accepted       = acc_ff;
         out_in.status         = status_ff;
         out_in.dropped_count  = dropped_ff;
         out_in.clock_adjusted = adj_ff;
         out_in.local_time     = SB'(lt_calc);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grace_ff    <= pfcs_pkg::GRACE_RESET;
         margin_ff   <= pfcs_pkg::MARGIN_RESET;
         marker_ff   <= pfcs_pkg::MARKER_RESET;
         epoch_ff    <= '0;
         count_ff    <= '0;
         pending_ff  <= 1'b0;
         num_ff      <= '0;
         rem_ff      <= '0;
         scan_idx_ff <= '0;
         div_cnt_ff  <= '0;
         for (int k = 0; k < PLAYERS; k++) begin
            last_stamp_ff[k] <= '0;
            last_seq_ff[k]   <= '0;
         end
      end else begin
         grace_ff      <= grace_in;
         margin_ff     <= margin_in;
         marker_ff     <= marker_in;
         epoch_ff      <= epoch_in;
         count_ff      <= count_in;
         pending_ff    <= pending_in;
         num_ff        <= num_in;
         rem_ff        <= rem_in;
         scan_idx_ff   <= scan_idx_in;
         div_cnt_ff    <= div_cnt_in;
         last_stamp_ff <= last_stamp_in;
         last_seq_ff   <= last_seq_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      ts_ff      <= ts_in;
      sum_ff     <= sum_in;
      acc_ff     <= acc_in;
      status_ff  <= status_in;
      dropped_ff <= dropped_in;
      adj_ff     <= adj_in;
      out_ff     <= out_in;
   end

   assign rsp_data = out_ff;

   a_pending_clear: assert property (@(posedge clock) disable iff (reset)
      $fell(pending_ff) |-> ($past(cmd.do_adjust) || $past(reset)))
      else $error("resync flag dropped without an epoch shift");

   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      (num_ff != '0) |-> (rem_ff < num_ff))
      else $error("divider remainder not below divisor");

   a_result_consistent: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> ((out_ff.accepted || !out_ff.clock_adjusted) &&
                        (!out_ff.accepted || (out_ff.status == pfcs_pkg::STATUS_OK))))
      else $error("result beat flags inconsistent");

endmodule

// ----- rtl/packet_freshness_and_clock_sync.sv -----
// Top level of the packet freshness and clock sync block.
// One item is taken at a time. A packet that needs no resync passes the time and
// check states before its result is loaded, a restart command the time state
// only. A packet that triggers resync adds a walk over the peer table, a
// bit-serial divider over the SW-bit sum that forms the average, whose first step
// also tests the count (SW = max(TIME_BITS, 48) + 1 + clog2(PLAYERS), 51 at the
// defaults), and an epoch update; the division and update are skipped when no
// teammate is far enough ahead. The result sits in an output register; if it has
// not been taken when the next result is ready, the block holds until it is.
module packet_freshness_and_clock_sync #(
   parameter int PLAYERS   = 4,
   parameter int TIME_BITS = 48
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  pfcs_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output pfcs_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_write_enable,
   input  logic [pfcs_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [pfcs_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);

   pfcs_pkg::cmd_type  cmd;
   pfcs_pkg::stat_type stat;

   pfcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pfcs_datapath #(
      .PLAYERS   (PLAYERS),
      .TIME_BITS (TIME_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_data         (req_data),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_data         (rsp_data)
   );

endmodule
